### sv/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
// No dependencies; imported by masked_byte_pattern_scan.
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_PATTERN_LOW  = 3'd0;
  localparam cfg_idx_t REG_PATTERN_HIGH = 3'd1;
  localparam cfg_idx_t REG_CARE_MASK    = 3'd2;
  localparam cfg_idx_t REG_PATTERN_LEN  = 3'd3;
  localparam cfg_idx_t REG_BASE_ADDR    = 3'd4;

  localparam int ADDR_W    = 64;
  localparam int PAT_BYTES = 16;
  localparam int CFG_LEN_W = 5;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [7:0]             byte_t;
  typedef logic [PAT_BYTES-1:0]   care_t;
  typedef logic [CFG_LEN_W-1:0]   cfg_len_t;

endpackage : mbps_pkg

`default_nettype wire

### sv/masked_byte_pattern_scan.sv
// Masked byte pattern scanner: window register, masked compare, result stages.
// Depends on mbps_pkg for register indexes and field types.
`timescale 1ns / 1ps
`default_nettype none

// Result path: a byte that causes a result has its compare and offset done at accept into
//   the s1 stage, then the address add is done into the output register.
// Throughput: one byte per cycle while in_tready is high; the window compare and the
//   base-address add stall only when the output register is held by out_tready.
// Reset (rst_n low, synchronous): scan state and both result stages empty, pattern
//   registers zero, pattern length one. The window bytes are not cleared.
module masked_byte_pattern_scan
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN  = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] match_address
  output logic             out_tuser,  // found
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire cfg_idx_t    cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = $clog2(MAX_PATTERN);

  // ---------------- configuration registers ----------------
  logic [63:0] pat_low_r, pat_high_r;
  care_t       care_r;
  cfg_len_t    len_r;
  addr_t       base_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      care_r     <= '0;
      len_r      <= cfg_len_t'(1);
      base_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pat_low_r  <= cfg_data;
        REG_PATTERN_HIGH: pat_high_r <= cfg_data;
        REG_CARE_MASK:    care_r     <= cfg_data[PAT_BYTES-1:0];
        REG_PATTERN_LEN:  len_r      <= cfg_data[CFG_LEN_W-1:0];
        REG_BASE_ADDR:    base_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- scan state ----------------
  byte_t                   win_r [MAX_PATTERN];
  byte_t                   win_nxt [MAX_PATTERN];
  logic [LEN_W-1:0]        seen_r, seen_nxt, seen_inc;
  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt;
  logic                    done_r, done_nxt;

  logic                    in_xfer;
  logic [LEN_W-1:0]        len_use, len_m1;
  logic [2*64-1:0]         pat_flat;
  logic                    hit, match, emit;
  logic [OFFSET_WIDTH-1:0] start_off;

  assign in_xfer  = in_tvalid && in_tready;
  assign pat_flat = {pat_high_r, pat_low_r};

  // length zero acts as one, lengths above the window saturate
  always_comb begin
    if (len_r == '0) begin
      len_use = LEN_W'(1);
    end else if (len_r > CFG_LEN_W'(MAX_PATTERN)) begin
      len_use = LEN_W'(MAX_PATTERN);
    end else begin
      len_use = len_r[LEN_W-1:0];
    end
  end
  assign len_m1 = len_use - LEN_W'(1);

  // shifted window, newest byte at entry 0
  always_comb begin
    win_nxt[0] = in_tdata;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  assign seen_inc = (seen_r == LEN_W'(MAX_PATTERN)) ? seen_r : seen_r + LEN_W'(1);

  // pattern byte j lines up with window entry len-1-j
  always_comb begin
    logic [LEN_W-1:0] idx;
    hit = 1'b1;
    idx = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      idx = len_m1 - LEN_W'(j);
      if ((LEN_W'(j) < len_use) && care_r[j] &&
          (win_nxt[idx[IDX_W-1:0]] != pat_flat[8*j +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  assign match     = hit && (seen_inc >= len_use);
  assign emit      = in_xfer && !done_r && (match || in_tlast);
  assign start_off = pos_r - {{(OFFSET_WIDTH-LEN_W){1'b0}}, len_m1};

  always_comb begin
    seen_nxt = seen_r;
    pos_nxt  = pos_r;
    done_nxt = done_r;
    if (in_xfer) begin
      if (in_tlast) begin
        seen_nxt = '0;
        pos_nxt  = '0;
        done_nxt = 1'b0;
      end else if (!done_r) begin
        seen_nxt = seen_inc;
        pos_nxt  = pos_r + OFFSET_WIDTH'(1);
        done_nxt = match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      pos_r  <= '0;
      done_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
    end
  end

  // window bytes only matter once enough of the current region is in
  always_ff @(posedge clk) begin
    if (in_xfer && !done_r) begin
      win_r <= win_nxt;
    end
  end

  // ---------------- result stages ----------------
  logic                    s1_valid_r, s1_found_r;
  logic [OFFSET_WIDTH-1:0] s1_start_r;
  logic                    s1_adv;
  logic                    out_valid_r, out_found_r;
  addr_t                   out_addr_r;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && emit) begin
      s1_found_r <= match;
      s1_start_r <= start_off;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_found_r <= s1_found_r;
      out_addr_r  <= s1_found_r ? base_r + ADDR_W'(s1_start_r) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_addr_r;

  // ---------------- checks ----------------
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result carries nonzero address");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= LEN_W'(MAX_PATTERN))
    else $error("byte count past window depth");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && done_r |=> !s1_valid_r)
    else $error("byte after a match produced a result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> seen_r == '0 && !done_r && pos_r == '0)
    else $error("region end did not clear scan state");

endmodule : masked_byte_pattern_scan

`default_nettype wire

### bench/masked_byte_pattern_scan_test.sv
// Testbench for masked_byte_pattern_scan: streams byte regions against several pattern
// settings, predicts each found / not-found report and checks every result transfer.
// Depends on mbps_pkg and the masked_byte_pattern_scan RTL.
`timescale 1ns / 1ps

module masked_byte_pattern_scan_test;
  import mbps_pkg::*;

  localparam int       OFS_W       = 32;
  localparam int       QUIET_LIMIT = 4000;
  localparam int       ITEM_TARGET = 520;
  localparam int       HOLD_CYCLES = 300;
  localparam cfg_idx_t REG_SPARE   = 3'd7;  // unmapped index, write must be dropped

  typedef struct {
    byte_t data;
    logic  last;
  } scan_item_t;

  typedef struct {
    logic  found;
    addr_t addr;
  } scan_report_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  wire         in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [63:0] out_tdata;
  wire         out_tuser;
  logic        cfg_valid  = 1'b0;
  wire         cfg_ready;
  cfg_idx_t    cfg_index  = REG_PATTERN_LOW;
  logic [63:0] cfg_data   = '0;

  masked_byte_pattern_scan dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // stimulus / scoreboard state
  scan_item_t   byte_queue[$];
  scan_report_t awaited_reports[$];
  bit           calm          = 1'b0;
  bit           long_hold_req = 1'b0;
  int           bytes_queued    = 0;
  int           bytes_accepted  = 0;
  int           reports_checked = 0;
  int           matches_seen    = 0;
  int           cfg_writes      = 0;
  int           settings_used   = 0;
  int           errors          = 0;

  // pattern as the generator sees it
  byte_t        stim_pat[PAT_BYTES];
  care_t        stim_care;
  int unsigned  stim_len = 1;

  // scan model
  logic [63:0]      mdl_pat_lo;
  logic [63:0]      mdl_pat_hi;
  care_t            mdl_care;
  cfg_len_t         mdl_len;
  addr_t            mdl_base;
  byte_t            mdl_window[PAT_BYTES];
  int unsigned      mdl_seen;
  logic [OFS_W-1:0] mdl_pos;
  bit               mdl_done;

  function automatic int unsigned eff_length(cfg_len_t raw);
    if (raw == 0) return 1;
    if (raw > PAT_BYTES) return PAT_BYTES;
    return raw;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void clear_scan();
    for (int k = 0; k < PAT_BYTES; k++) mdl_window[k] = '0;
    mdl_seen = 0;
    mdl_pos  = '0;
    mdl_done = 1'b0;
  endfunction

  // Shift one byte into the window and queue the report it causes, if any.
  function automatic void scan_byte(byte_t data, logic last);
    int unsigned      len;
    logic [OFS_W-1:0] pos;
    logic [OFS_W-1:0] start;
    logic [63:0]      word;
    byte_t            pbyte;
    bit               hit;
    if (mdl_done) begin
      if (last) clear_scan();
      return;
    end
    for (int k = PAT_BYTES - 1; k > 0; k--) mdl_window[k] = mdl_window[k-1];
    mdl_window[0] = data;
    if (mdl_seen < PAT_BYTES) mdl_seen++;
    pos     = mdl_pos;
    mdl_pos = pos + 1'b1;
    len     = eff_length(mdl_len);
    hit     = (mdl_seen >= len);
    // pattern byte 0 lines up with the oldest byte of the window slice
    for (int j = 0; j < len; j++) begin
      word  = (j < 8) ? mdl_pat_lo : mdl_pat_hi;
      pbyte = word[(j % 8) * 8 +: 8];
      if (mdl_care[j] && mdl_window[len - 1 - j] != pbyte) hit = 1'b0;
    end
    if (hit) begin
      start = pos - (len - 1);
      awaited_reports.insert(awaited_reports.size(), '{1'b1, mdl_base + start});
      if (last) clear_scan();
      else mdl_done = 1'b1;
    end else if (last) begin
      awaited_reports.insert(awaited_reports.size(), '{1'b0, '0});
      clear_scan();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mdl_pat_lo = '0;
      mdl_pat_hi = '0;
      mdl_care   = '0;
      mdl_len    = 5'd1;
      mdl_base   = '0;
      clear_scan();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LOW:  mdl_pat_lo = cfg_data;
          REG_PATTERN_HIGH: mdl_pat_hi = cfg_data;
          REG_CARE_MASK:    mdl_care   = cfg_data[PAT_BYTES-1:0];
          REG_PATTERN_LEN:  mdl_len    = cfg_data[CFG_LEN_W-1:0];
          REG_BASE_ADDR:    mdl_base   = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        scan_byte(in_tdata, in_tlast);
        bytes_accepted++;
      end
    end
  end

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= byte_queue[0].data;
        in_tlast  <= byte_queue[0].last;
        void'(byte_queue.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  int  hold_left  = 0;
  bit  hold_taken = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 10);
    end
  end

  // result monitor
  always @(posedge clk) begin : check_reports
    scan_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_reports.size() == 0) begin
        $error("result with nothing expected: found %0b match_address %h",
               out_tuser, out_tdata);
        errors++;
      end else begin
        want = awaited_reports.pop_front();
        if (out_tuser !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_tuser);
          errors++;
        end
        if (out_tdata !== want.addr) begin
          $error("match_address: expected %h, got %h", want.addr, out_tdata);
          errors++;
        end
        if (want.found) matches_seen++;
        reports_checked++;
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet < QUIET_LIMIT) begin
      quiet <= quiet + 1;
    end else begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void queue_byte(byte_t data, logic last);
    byte_queue.insert(byte_queue.size(), '{data, last});
    bytes_queued++;
  endfunction

  task automatic cfg_write(cfg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Upper bits of the narrow registers carry junk; only the low bits count.
  task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, care_t care,
                              cfg_len_t len_raw, addr_t base);
    for (int j = 0; j < PAT_BYTES; j++)
      stim_pat[j] = (j < 8) ? lo[j*8 +: 8] : hi[(j-8)*8 +: 8];
    stim_care = care;
    stim_len  = eff_length(len_raw);
    cfg_write(REG_PATTERN_LOW, lo);
    cfg_write(REG_PATTERN_HIGH, hi);
    cfg_write(REG_CARE_MASK, {$urandom, 16'($urandom), care});
    cfg_write(REG_PATTERN_LEN, {$urandom, 27'($urandom), len_raw});
    cfg_write(REG_BASE_ADDR, base);
    settings_used++;
  endtask

  task automatic random_settings();
    logic [63:0] lo;
    logic [63:0] hi;
    care_t       care;
    cfg_len_t    len_raw;
    addr_t       base;
    int unsigned pick;
    lo   = rand64();
    hi   = rand64();
    pick = $urandom_range(9);
    if (pick == 0) begin
      lo = '0;
      hi = '0;
    end else if (pick == 1) begin
      lo = '1;
      hi = '1;
    end
    pick = $urandom_range(9);
    care = (pick == 0) ? '0 : (pick == 1) ? '1 : care_t'($urandom);
    case ($urandom_range(15))
      0:       len_raw = 5'd0;
      1:       len_raw = 5'($urandom_range(17, 31));
      2:       len_raw = 5'd31;
      3:       len_raw = 5'd16;
      4:       len_raw = 5'($urandom_range(9, 15));
      default: len_raw = 5'($urandom_range(1, 6));
    endcase
    pick = $urandom_range(9);
    base = (pick == 0) ? '0 : (pick == 1) ? '1 :
           (pick == 2) ? ('1 - addr_t'($urandom_range(40))) : rand64();
    load_pattern(lo, hi, care, len_raw, base);
  endtask

  // Mostly a planted pattern between random bytes; some with a corrupted
  // byte, some pure noise. Every region ends with last set.
  function automatic void add_region();
    int unsigned roll;
    int unsigned pre;
    int unsigned post;
    int unsigned broken;
    byte_t       b;
    roll = $urandom_range(99);
    if (roll < 15) begin
      pre = $urandom_range(1, 30);
      for (int i = 0; i < pre; i++) queue_byte(byte_t'($urandom), i == pre - 1);
      return;
    end
    pre    = $urandom_range(0, 12);
    post   = $urandom_range(0, 4);
    broken = (roll < 30) ? $urandom_range(0, stim_len - 1) : PAT_BYTES;
    for (int i = 0; i < pre; i++) queue_byte(byte_t'($urandom), 1'b0);
    for (int j = 0; j < stim_len; j++) begin
      b = stim_care[j] ? stim_pat[j] : byte_t'($urandom);
      if (j == broken) b = b ^ byte_t'($urandom_range(1, 255));
      queue_byte(b, post == 0 && j == stim_len - 1);
    end
    for (int i = 0; i < post; i++) queue_byte(byte_t'($urandom), i == post - 1);
  endfunction

  // Wait until every queued byte is taken and every report is in, then let
  // the pipeline settle since trailing bytes may cause no report.
  task automatic drain();
    while (bytes_accepted != bytes_queued || awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one-byte pattern, all wildcard
    queue_byte(8'h00, 1'b1);
    drain();

    // base near the top so the match address wraps; pattern byte 3 is a wildcard
    load_pattern(64'h0123_4567_C35A_FF00, rand64(), 16'h0007, 5'd4,
                 64'hFFFF_FFFF_FFFF_FFFE);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'h99, 1'b0);
    queue_byte(8'h44, 1'b1);   // after the match, ignored
    // region shorter than the pattern
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // length changed mid-region, zero length acts as one
    queue_byte(8'h80, 1'b0);
    drain();
    cfg_write(REG_PATTERN_LEN, 64'd0);
    cfg_write(REG_SPARE, rand64());
    queue_byte(8'h00, 1'b1);
    drain();

    // oversize length saturates to a full 16-byte compare
    load_pattern(64'h8877_6655_4433_2211, 64'h00FF_EEDD_CCBB_AA99, 16'hFFFF, 5'd31,
                 64'h0000_0000_0000_1000);
    for (int j = 0; j < PAT_BYTES; j++) queue_byte(stim_pat[j], j == PAT_BYTES - 1);
    drain();

    // a stretch with no idling on either side
    calm = 1'b1;
    random_settings();
    repeat (6) add_region();
    drain();
    calm = 1'b0;

    // every region reports on its first byte while the receiver holds off
    load_pattern(rand64(), rand64(), '0, 5'd1, rand64());
    long_hold_req = 1'b1;
    repeat (50) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) queue_byte(byte_t'($urandom), i == n - 1);
    end
    drain();

    while (bytes_queued < ITEM_TARGET) begin
      random_settings();
      repeat ($urandom_range(3, 8)) add_region();
      drain();
    end

    repeat (12) @(posedge clk);
    if (awaited_reports.size() != 0) begin
      $error("%0d expected results never arrived", awaited_reports.size());
      errors++;
    end
    $display("covered %0d bytes over %0d pattern settings (%0d register writes)",
             bytes_accepted, settings_used, cfg_writes);
    $display("checked %0d results: %0d matches, %0d scans without a match",
             reports_checked, matches_seen, reports_checked - matches_seen);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/mbps_pkg.sv
sv/masked_byte_pattern_scan.sv
bench/masked_byte_pattern_scan_test.sv
